[design/assert_macros.svh]
// Assertion macros shared by the RTL files of the RPN calculator.
// No dependencies; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define RPN_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rpn assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define RPN_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rpn assertion failed");
`else
`define RPN_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define RPN_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

[design/rpn_pkg.sv]
// Types and constants for the RPN stack calculator.
// No dependencies; used by rpn_stack_calculator_unit.
package rpn_pkg;

  // Request codes
  localparam logic [2:0] REQ_PUSH  = 3'd0;
  localparam logic [2:0] REQ_ADD   = 3'd1;
  localparam logic [2:0] REQ_SUB   = 3'd2;
  localparam logic [2:0] REQ_MUL   = 3'd3;
  localparam logic [2:0] REQ_DIV   = 3'd4;
  localparam logic [2:0] REQ_PRINT = 3'd5;

  // Q16.16 limits
  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

  // Divider: 48-bit dividend (|left| << 16), one quotient bit per cycle
  localparam int DIV_BITS  = 48;
  localparam int DIV_CNT_W = 6;

  typedef struct packed {
    logic        [2:0]  req_type;
    logic signed [31:0] number;
  } in_t;

  typedef struct packed {
    logic signed [31:0] printed_value;
    logic               printed;
    logic        [1:0]  underflows;
    logic               overflow;
    logic               zero_divisor;
    logic               unknown_command;
  } out_t;

endpackage

[design/rpn_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the value stack of the RPN calculator.
module rpn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[design/rpn_stack_calculator_unit.sv]
// Top level of the RPN stack calculator: sequencer, shared adder, divider loop.
// Depends on rpn_pkg, rpn_ram and assert_macros.svh.
//
//  Channel  | Ports                          | Beat carries
//  ---------+--------------------------------+------------------------------
//  input    | in_valid, in_ready, in_data    | rpn_pkg::in_t  (one token)
//  result   | out_valid, out_ready, out_data | rpn_pkg::out_t (one report)
//
// One token at a time; in_ready is high only while the sequencer is idle.
// Push and unknown commands report straight from idle; print reports after one pop.
// Divide runs the 48-step restoring loop at one quotient bit per cycle, and reports a
// zero divisor after the first pop. A pop reads the RAM; an empty-stack pop does not.
// Reset empties the stack at once; stack contents need no clearing.
// A stalled result holds in the output register until out_ready.
`include "assert_macros.svh"

module rpn_stack_calculator_unit #(
  parameter int STACK_DEPTH = 128
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  rpn_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output rpn_pkg::out_t  out_data
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_POP  = 8'b0000_0010,
    S_LOAD = 8'b0000_0100,
    S_EXEC = 8'b0000_1000,
    S_DIV  = 8'b0001_0000,
    S_SAT  = 8'b0010_0000,
    S_PUSH = 8'b0100_0000,
    S_OUT  = 8'b1000_0000
  } state_t;

  state_t                             state_r, state_nxt;
  logic [CW-1:0]                      count_r, count_nxt;
  logic [2:0]                         type_r, type_nxt;
  logic                               pop_left_r, pop_left_nxt;
  logic signed [31:0]                 l_r, l_nxt;
  logic signed [31:0]                 r_r, r_nxt;
  logic signed [31:0]                 res_r, res_nxt;
  logic signed [63:0]                 prod_r, prod_nxt;
  logic [rpn_pkg::DIV_BITS-1:0]       dvd_r, dvd_nxt;
  logic [31:0]                        rem_r, rem_nxt;
  logic [31:0]                        dsr_r, dsr_nxt;
  logic                               neg_r, neg_nxt;
  logic [rpn_pkg::DIV_CNT_W-1:0]      cnt_r, cnt_nxt;
  rpn_pkg::out_t                      out_r, out_nxt;

  // Shared add/subtract unit
  logic signed [33:0] alu_a, alu_b, alu_sum;
  logic               alu_sub;

  // Stack RAM ports
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [31:0]   ram_wdata, ram_rdata;

  // Pop completion
  logic               pop_done;
  logic signed [31:0] pop_val;

  logic [CW-1:0]      cnt_dec;
  logic signed [63:0] prod_sh;
  logic [31:0]        l_mag, r_mag;

  assign alu_sum = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
  assign cnt_dec = count_r - 1'b1;
  assign prod_sh = prod_r >>> 16;
  assign l_mag   = l_r[31] ? (~l_r + 32'd1) : l_r;
  assign r_mag   = r_r[31] ? (~r_r + 32'd1) : r_r;

  rpn_ram #(
    .WIDTH(32),
    .DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Sequencer
  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    type_nxt     = type_r;
    pop_left_nxt = pop_left_r;
    l_nxt        = l_r;
    r_nxt        = r_r;
    res_nxt      = res_r;
    prod_nxt     = prod_r;
    dvd_nxt      = dvd_r;
    rem_nxt      = rem_r;
    dsr_nxt      = dsr_r;
    neg_nxt      = neg_r;
    cnt_nxt      = cnt_r;
    out_nxt      = out_r;
    alu_a        = '0;
    alu_b        = '0;
    alu_sub      = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = count_r[AW-1:0];
    ram_wdata    = res_r;
    ram_raddr    = cnt_dec[AW-1:0];
    pop_done     = 1'b0;
    pop_val      = '0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          type_nxt     = in_data.req_type;
          pop_left_nxt = 1'b0;
          out_nxt      = '0;
          case (in_data.req_type)
            rpn_pkg::REQ_PUSH: begin
              // Drop the value when the stack is full
              if (count_r == CW'(STACK_DEPTH)) begin
                out_nxt.overflow = 1'b1;
              end else begin
                ram_we    = 1'b1;
                ram_wdata = in_data.number;
                count_nxt = count_r + 1'b1;
              end
              state_nxt = S_OUT;
            end
            rpn_pkg::REQ_ADD, rpn_pkg::REQ_SUB, rpn_pkg::REQ_MUL,
            rpn_pkg::REQ_DIV, rpn_pkg::REQ_PRINT: begin
              state_nxt = S_POP;
            end
            default: begin
              out_nxt.unknown_command = 1'b1;
              state_nxt               = S_OUT;
            end
          endcase
        end
      end
      S_POP: begin
        // Empty stack yields zero and counts an underflow
        if (count_r == '0) begin
          out_nxt.underflows = out_r.underflows + 2'd1;
          pop_done           = 1'b1;
        end else begin
          count_nxt = cnt_dec;
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        pop_val  = ram_rdata;
        pop_done = 1'b1;
      end
      S_EXEC: begin
        case (type_r)
          rpn_pkg::REQ_ADD, rpn_pkg::REQ_SUB: begin
            alu_a   = 34'(l_r);
            alu_b   = 34'(r_r);
            alu_sub = (type_r == rpn_pkg::REQ_SUB);
            if (alu_sum[33:31] == 3'b000 || alu_sum[33:31] == 3'b111) begin
              res_nxt = alu_sum[31:0];
            end else begin
              res_nxt = alu_sum[33] ? rpn_pkg::Q_MIN : rpn_pkg::Q_MAX;
            end
            state_nxt = S_PUSH;
          end
          rpn_pkg::REQ_MUL: begin
            prod_nxt  = l_r * r_r;
            state_nxt = S_SAT;
          end
          rpn_pkg::REQ_DIV: begin
            // Load magnitudes; the sign is applied after the loop
            dvd_nxt   = {l_mag, 16'h0000};
            dsr_nxt   = r_mag;
            rem_nxt   = '0;
            neg_nxt   = l_r[31] ^ r_r[31];
            cnt_nxt   = '0;
            state_nxt = S_DIV;
          end
          default: begin
            state_nxt = S_OUT;
          end
        endcase
      end
      S_DIV: begin
        // One restoring step: shift in a dividend bit, try to subtract
        alu_a   = {1'b0, rem_r, dvd_r[rpn_pkg::DIV_BITS-1]};
        alu_b   = {2'b00, dsr_r};
        alu_sub = 1'b1;
        if (!alu_sum[33]) begin
          rem_nxt = alu_sum[31:0];
        end else begin
          rem_nxt = {rem_r[30:0], dvd_r[rpn_pkg::DIV_BITS-1]};
        end
        dvd_nxt = {dvd_r[rpn_pkg::DIV_BITS-2:0], ~alu_sum[33]};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == rpn_pkg::DIV_CNT_W'(rpn_pkg::DIV_BITS - 1)) begin
          state_nxt = S_SAT;
        end
      end
      S_SAT: begin
        if (type_r == rpn_pkg::REQ_MUL) begin
          // Product already floored by the arithmetic shift
          if (prod_sh[63:31] == '0 || prod_sh[63:31] == '1) begin
            res_nxt = prod_sh[31:0];
          end else begin
            res_nxt = prod_sh[63] ? rpn_pkg::Q_MIN : rpn_pkg::Q_MAX;
          end
        end else if (neg_r) begin
          if (dvd_r[47:32] != '0 || (dvd_r[31] && dvd_r[30:0] != '0)) begin
            res_nxt = rpn_pkg::Q_MIN;
          end else begin
            res_nxt = ~dvd_r[31:0] + 32'd1;
          end
        end else begin
          if (dvd_r[47:31] != '0) begin
            res_nxt = rpn_pkg::Q_MAX;
          end else begin
            res_nxt = dvd_r[31:0];
          end
        end
        state_nxt = S_PUSH;
      end
      S_PUSH: begin
        // Two pops leave room, so the result always fits
        ram_we    = 1'b1;
        count_nxt = count_r + 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Route a finished pop: right operand first, then left
    if (pop_done) begin
      if (!pop_left_r) begin
        r_nxt = pop_val;
        if (type_r == rpn_pkg::REQ_PRINT) begin
          out_nxt.printed       = 1'b1;
          out_nxt.printed_value = pop_val;
          state_nxt             = S_OUT;
        end else if (type_r == rpn_pkg::REQ_DIV && pop_val == '0) begin
          out_nxt.zero_divisor = 1'b1;
          state_nxt            = S_OUT;
        end else begin
          pop_left_nxt = 1'b1;
          state_nxt    = S_POP;
        end
      end else begin
        l_nxt     = pop_val;
        state_nxt = S_EXEC;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      count_r    <= '0;
      pop_left_r <= 1'b0;
      cnt_r      <= '0;
    end else begin
      state_r    <= state_nxt;
      count_r    <= count_nxt;
      pop_left_r <= pop_left_nxt;
      cnt_r      <= cnt_nxt;
    end
  end

  // Datapath and result registers
  always_ff @(posedge clk) begin
    type_r <= type_nxt;
    l_r    <= l_nxt;
    r_r    <= r_nxt;
    res_r  <= res_nxt;
    prod_r <= prod_nxt;
    dvd_r  <= dvd_nxt;
    rem_r  <= rem_nxt;
    dsr_r  <= dsr_nxt;
    neg_r  <= neg_nxt;
    out_r  <= out_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_data  = out_r;

  `RPN_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_r <= CW'(STACK_DEPTH))
  `RPN_ASSERT_NXT(a_return_idle, clk, rst_n, out_valid && out_ready, in_ready)
  `RPN_ASSERT_IMP(a_zdiv_only_div, clk, rst_n, out_valid && out_data.zero_divisor,
                  type_r == rpn_pkg::REQ_DIV)
  `RPN_ASSERT_IMP(a_value_only_print, clk, rst_n, out_valid && !out_data.printed,
                  out_data.printed_value == '0)

endmodule
